>>> rtl/lkvc_pkg.sv
// Package for the LRU key/value cache: geometry constants and the item types.
// No dependencies; used by lkvc_store and lru_key_value_cache.
package lkvc_pkg;

  localparam int unsigned CAPACITY = 16;
  localparam int unsigned IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CNT_W    = $clog2(CAPACITY + 1);
  localparam int unsigned KEY_W    = 32;
  localparam int unsigned VAL_W    = 32;
  localparam int unsigned CFG_W    = 5;

  localparam logic [CFG_W-1:0]        CAP_RESET  = CFG_W'(16);
  localparam logic signed [VAL_W-1:0] MISS_VALUE = -32'sd1;

  typedef enum logic {
    CMD_GET = 1'b0,
    CMD_PUT = 1'b1
  } cmd_e;

  typedef struct packed {
    cmd_e                    command;
    logic signed [KEY_W-1:0] lookup_key;
    logic signed [VAL_W-1:0] write_value;
  } in_item_t;

  typedef struct packed {
    logic                    found;
    logic signed [VAL_W-1:0] read_value;
    logic                    evicted;
  } out_item_t;

  // Request from the handshake stage to the store
  typedef struct packed {
    logic             fire;
    logic [CNT_W-1:0] cap;
    in_item_t         item;
  } store_req_t;

endpackage

>>> rtl/lkvc_store.sv
// Entry store of the LRU cache: keys, values, valid bits, recency ranks, fill count.
// Parallel, combinational key match, rank update, eviction, insertion. Uses lkvc_pkg.
module lkvc_store (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  lkvc_pkg::store_req_t   req_i,
  output lkvc_pkg::out_item_t    rsp_o
);
  import lkvc_pkg::*;

  logic [KEY_W-1:0] key_q   [CAPACITY];
  logic [VAL_W-1:0] value_q [CAPACITY];
  logic [CAPACITY-1:0] valid_q, valid_d;
  logic [IDX_W-1:0] rank_q [CAPACITY];
  logic [IDX_W-1:0] rank_d [CAPACITY];
  logic [CNT_W-1:0] count_q, count_d, count_mid;

  logic             hit;
  logic [IDX_W-1:0] hit_idx;
  logic [IDX_W-1:0] hit_rank;
  logic             evict_found;
  logic [IDX_W-1:0] evict_idx;
  logic             do_evict;
  logic             free_found;
  logic [IDX_W-1:0] free_idx;
  logic             wr_en;
  logic             wr_key_en;
  logic [IDX_W-1:0] wr_idx;

  always_comb begin
    hit         = 1'b0;
    hit_idx     = '0;
    evict_found = 1'b0;
    evict_idx   = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (valid_q[i] && key_q[i] == req_i.item.lookup_key) begin
        hit     = 1'b1;
        hit_idx = IDX_W'(i);
      end
      // least recent entry carries rank count-1
      if (!evict_found && valid_q[i] && count_q != '0 &&
          CNT_W'(rank_q[i]) == count_q - CNT_W'(1)) begin
        evict_found = 1'b1;
        evict_idx   = IDX_W'(i);
      end
    end
    hit_rank = rank_q[hit_idx];
  end

  always_comb begin
    valid_d    = valid_q;
    rank_d     = rank_q;
    count_d    = count_q;
    count_mid  = count_q;
    do_evict   = 1'b0;
    free_found = 1'b0;
    free_idx   = '0;
    wr_en      = 1'b0;
    wr_key_en  = 1'b0;
    wr_idx     = hit_idx;

    if (req_i.fire) begin
      if (hit) begin
        // move to front: entries more recent than it fall back one place
        for (int i = 0; i < CAPACITY; i++) begin
          if (valid_q[i] && rank_q[i] < hit_rank) begin
            rank_d[i] = rank_q[i] + IDX_W'(1);
          end
        end
        rank_d[hit_idx] = '0;
        wr_en = (req_i.item.command == CMD_PUT);
      end else if (req_i.item.command == CMD_PUT) begin
        do_evict = (count_q >= req_i.cap) && evict_found;
        if (do_evict) begin
          valid_d[evict_idx] = 1'b0;
          rank_d[evict_idx]  = '0;
        end
        count_mid = count_q - CNT_W'(do_evict);
        for (int i = 0; i < CAPACITY; i++) begin
          if (!free_found && !valid_d[i]) begin
            free_found = 1'b1;
            free_idx   = IDX_W'(i);
          end
        end
        count_d = count_mid;
        if (req_i.cap != '0 && 32'(count_mid) < 32'(CAPACITY) && free_found) begin
          for (int i = 0; i < CAPACITY; i++) begin
            if (valid_d[i]) begin
              rank_d[i] = rank_d[i] + IDX_W'(1);
            end
          end
          valid_d[free_idx] = 1'b1;
          rank_d[free_idx]  = '0;
          count_d   = count_mid + CNT_W'(1);
          wr_en     = 1'b1;
          wr_key_en = 1'b1;
          wr_idx    = free_idx;
        end
      end
    end
  end

  always_comb begin
    rsp_o.found   = hit;
    rsp_o.evicted = do_evict;
    if (req_i.item.command == CMD_PUT) begin
      rsp_o.read_value = '0;
    end else if (hit) begin
      rsp_o.read_value = value_q[hit_idx];
    end else begin
      rsp_o.read_value = MISS_VALUE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      count_q <= '0;
      for (int i = 0; i < CAPACITY; i++) begin
        rank_q[i] <= '0;
      end
    end else begin
      valid_q <= valid_d;
      count_q <= count_d;
      rank_q  <= rank_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      value_q[wr_idx] <= req_i.item.write_value;
    end
    if (wr_key_en) begin
      key_q[wr_idx] <= req_i.item.lookup_key;
    end
  end

endmodule

>>> rtl/lru_key_value_cache.sv
// Fully associative key/value cache with least-recently-used replacement.
// Result path: the input item is registered in in_item_q, then the store response is registered in out_item_q.
// Throughput: one item per cycle while out_stall_i is low; the whole match and rank update is combinational against
// registered state in lkvc_store. Reset: cache empty, capacity register 16, no item held.
// Depends on lkvc_pkg and lkvc_store.
module lru_key_value_cache (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  lkvc_pkg::in_item_t       in_item_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output lkvc_pkg::out_item_t      out_item_o,
  input  logic                     cfg_valid_i,
  output logic                     cfg_ready_o,
  input  logic [lkvc_pkg::CFG_W-1:0] cfg_data_i
);
  import lkvc_pkg::*;

  logic             cap_cfg_en;
  logic [CFG_W-1:0] cap_q;
  logic [CNT_W-1:0] cap_eff;
  logic             in_vld_q;
  in_item_t         in_item_q;
  logic             out_vld_q;
  out_item_t        out_item_q;
  logic             res_ready;
  store_req_t       req;
  out_item_t        rsp;

  assign cfg_ready_o = 1'b1;
  assign cap_cfg_en  = cfg_valid_i && cfg_ready_o;

  // saturate to the physical entry count
  assign cap_eff = (32'(cap_q) > 32'(CAPACITY)) ? CNT_W'(CAPACITY) : CNT_W'(cap_q);

  assign res_ready  = !out_vld_q || !out_stall_i;
  assign in_stall_o = in_vld_q && !res_ready;

  assign req.fire = in_vld_q && res_ready;
  assign req.cap  = cap_eff;
  assign req.item = in_item_q;

  lkvc_store u_store (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req),
    .rsp_o  (rsp)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q     <= CAP_RESET;
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (cap_cfg_en) begin
        cap_q <= cfg_data_i;
      end
      if (!in_stall_o) begin
        in_vld_q <= in_valid_i;
      end
      if (res_ready) begin
        out_vld_q <= in_vld_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      in_item_q <= in_item_i;
    end
    if (req.fire) begin
      out_item_q <= rsp;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_item_o  = out_item_q;

endmodule

>>> tb/tb_top.sv
// Self-checking bench for lru_key_value_cache: directed and random get/put traffic
// with capacity changes between phases, checked against a shadow LRU store.
// Depends on lkvc_pkg and the cache RTL.
`timescale 1ns / 100ps

module tb_top;
  import lkvc_pkg::*;

  typedef struct packed {
    bit               is_cfg;
    logic [CFG_W-1:0] cap;
    in_item_t         item;
  } pending_op_t;

  logic              clk_i;
  logic              rst_ni      = 1'b0;
  logic              in_valid_i  = 1'b0;
  logic              in_stall_o;
  in_item_t          in_item_i   = '0;
  logic              out_valid_o;
  logic              out_stall_i = 1'b0;
  out_item_t         out_item_o;
  logic              cfg_valid_i = 1'b0;
  logic              cfg_ready_o;
  logic [CFG_W-1:0]  cfg_data_i  = '0;

  lru_key_value_cache DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i)
  );

  // Shadow copy of the cache contents
  logic [KEY_W-1:0] shadow_key   [CAPACITY];
  logic [VAL_W-1:0] shadow_val   [CAPACITY];
  bit               shadow_valid [CAPACITY];
  int unsigned      shadow_rank  [CAPACITY];
  int unsigned      shadow_count;
  logic [CFG_W-1:0] cache_cap;

  pending_op_t pending_ops[$];
  out_item_t   expected_results[$];
  int unsigned n_sent;
  int unsigned n_seen;
  int unsigned errors;

  // Rank 0 is most recent; entries more recent than the slot age by one
  function automatic void make_most_recent(int unsigned slot);
    int unsigned r;
    r = shadow_rank[slot];
    for (int i = 0; i < CAPACITY; i++) begin
      if (shadow_valid[i] && shadow_rank[i] < r) shadow_rank[i]++;
    end
    shadow_rank[slot] = 0;
  endfunction

  function automatic out_item_t cache_access(in_item_t it);
    out_item_t   res;
    bit          hit;
    int unsigned hit_slot;
    int unsigned cap;
    int          free_slot;
    res      = '0;
    hit      = 1'b0;
    hit_slot = 0;
    cap      = (32'(cache_cap) > CAPACITY) ? CAPACITY : 32'(cache_cap);
    for (int i = 0; i < CAPACITY; i++) begin
      if (shadow_valid[i] && shadow_key[i] == it.lookup_key) begin
        hit      = 1'b1;
        hit_slot = i;
      end
    end
    if (it.command == CMD_GET) begin
      if (hit) begin
        res.read_value = shadow_val[hit_slot];
        make_most_recent(hit_slot);
      end else begin
        res.read_value = MISS_VALUE;
      end
    end else if (hit) begin
      shadow_val[hit_slot] = it.write_value;
      make_most_recent(hit_slot);
    end else begin
      // store full (or shrunk): drop the least recent before inserting
      if (shadow_count >= cap && shadow_count > 0) begin
        for (int i = 0; i < CAPACITY; i++) begin
          if (shadow_valid[i] && shadow_rank[i] == shadow_count - 1) begin
            shadow_valid[i] = 1'b0;
            shadow_rank[i]  = 0;
            res.evicted     = 1'b1;
            break;
          end
        end
        if (res.evicted) shadow_count--;
      end
      if (cap > 0 && shadow_count < CAPACITY) begin
        free_slot = -1;
        for (int i = 0; i < CAPACITY; i++) begin
          if (!shadow_valid[i]) begin
            free_slot = i;
            break;
          end
        end
        if (free_slot >= 0) begin
          for (int j = 0; j < CAPACITY; j++) begin
            if (shadow_valid[j]) shadow_rank[j]++;
          end
          shadow_valid[free_slot] = 1'b1;
          shadow_key[free_slot]   = it.lookup_key;
          shadow_val[free_slot]   = it.write_value;
          shadow_rank[free_slot]  = 0;
          shadow_count++;
        end
      end
    end
    res.found = hit;
    return res;
  endfunction

  task automatic add_access(cmd_e cmd, logic [KEY_W-1:0] key, logic [VAL_W-1:0] val);
    pending_op_t op;
    op                  = '0;
    op.item.command     = cmd;
    op.item.lookup_key  = key;
    op.item.write_value = val;
    pending_ops.push_back(op);
  endtask

  task automatic add_cap_write(logic [CFG_W-1:0] cap);
    pending_op_t op;
    op        = '0;
    op.is_cfg = 1'b1;
    op.cap    = cap;
    pending_ops.push_back(op);
  endtask

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Driver: one transfer at a time from pending_ops; capacity writes wait for idle
  int unsigned gap_left;
  int unsigned quiet_cycles;
  bit          no_gap;

  always @(posedge clk_i or negedge rst_ni) begin : driver
    logic nxt_valid;
    logic nxt_cfg;
    if (!rst_ni) begin
      in_valid_i   <= 1'b0;
      cfg_valid_i  <= 1'b0;
      gap_left     = 0;
      quiet_cycles = 0;
      no_gap       = 1'b0;
      n_sent       <= 0;
      shadow_count = 0;
      cache_cap    = CAP_RESET;
      for (int i = 0; i < CAPACITY; i++) begin
        shadow_valid[i] = 1'b0;
        shadow_rank[i]  = 0;
        shadow_key[i]   = '0;
        shadow_val[i]   = '0;
      end
    end else begin
      nxt_valid = in_valid_i;
      nxt_cfg   = cfg_valid_i;
      if (in_valid_i && !in_stall_o) begin
        expected_results.push_back(cache_access(in_item_i));
        n_sent    <= n_sent + 1;
        nxt_valid = 1'b0;
        gap_left  = no_gap ? 0 : $urandom_range(0, 15);
        if ($urandom_range(0, 39) == 0) no_gap = !no_gap;
      end
      if (cfg_valid_i && cfg_ready_o) begin
        cache_cap = cfg_data_i;
        nxt_cfg   = 1'b0;
      end
      if (in_valid_i || n_sent != n_seen) quiet_cycles = 0;
      else if (quiet_cycles < 255) quiet_cycles++;
      if (!nxt_valid && !nxt_cfg) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (pending_ops.size() > 0) begin
          if (!pending_ops[0].is_cfg) begin
            nxt_valid = 1'b1;
            in_item_i <= pending_ops[0].item;
            void'(pending_ops.pop_front());
          end else if (quiet_cycles >= 6) begin
            // pipeline drained: safe to change the capacity
            nxt_cfg    = 1'b1;
            cfg_data_i <= pending_ops[0].cap;
            void'(pending_ops.pop_front());
          end
        end
      end
      in_valid_i  <= nxt_valid;
      cfg_valid_i <= nxt_cfg;
    end
  end

  // Monitor: random stall per result, compare against oldest expectation
  int unsigned stall_left;
  bit          no_stall;

  always @(posedge clk_i or negedge rst_ni) begin : monitor
    out_item_t exp_res;
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      stall_left  = 0;
      no_stall    = 1'b0;
      n_seen      <= 0;
      errors      = 0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (expected_results.size() == 0) begin
          if (errors < 10) $display("unexpected result: found=%0b value=%0d evicted=%0b",
                                    out_item_o.found, out_item_o.read_value,
                                    out_item_o.evicted);
          errors++;
        end else begin
          exp_res = expected_results.pop_front();
          n_seen  <= n_seen + 1;
          if (out_item_o.found !== exp_res.found ||
              out_item_o.read_value !== exp_res.read_value ||
              out_item_o.evicted !== exp_res.evicted) begin
            if (errors < 10)
              $display({"mismatch #%0d: exp found=%0b value=%0d evicted=%0b,",
                        " act found=%0b value=%0d evicted=%0b"},
                       n_seen, exp_res.found, exp_res.read_value, exp_res.evicted,
                       out_item_o.found, out_item_o.read_value, out_item_o.evicted);
            errors++;
          end
        end
        stall_left = no_stall ? 0 : $urandom_range(0, 15);
        if ($urandom_range(0, 39) == 0) no_stall = !no_stall;
      end else if (stall_left > 0) begin
        stall_left--;
      end
      out_stall_i <= (stall_left > 0);
    end
  end

  initial begin : stimulus
    logic [CFG_W-1:0] phase_caps [12];
    logic [KEY_W-1:0] key_pool   [$];
    logic [KEY_W-1:0] key;
    int unsigned      eff_cap;
    phase_caps = '{5'd16, 5'd1, 5'd0, 5'd31, 5'd2, 5'd17, 5'd0, 5'd16, 5'd3, 5'd9, 5'd24, 5'd7};

    // Directed: key/value extremes at reset capacity
    add_access(CMD_GET, 32'h0000_0000, 32'h5555_5555);
    add_access(CMD_PUT, 32'h8000_0000, 32'h7FFF_FFFF);
    add_access(CMD_PUT, 32'h7FFF_FFFF, 32'h8000_0000);
    add_access(CMD_PUT, 32'hFFFF_FFFF, 32'h0000_0000);
    add_access(CMD_PUT, 32'h0000_0000, 32'hFFFF_FFFF);
    add_access(CMD_GET, 32'h8000_0000, 32'hAAAA_AAAA);
    add_access(CMD_GET, 32'h7FFF_FFFF, 32'h0000_0000);
    add_access(CMD_GET, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    add_access(CMD_GET, 32'h0000_0000, 32'h0000_0000);
    add_access(CMD_PUT, 32'h0000_0000, 32'h1234_5678);
    add_access(CMD_GET, 32'h0000_0000, 32'h0000_0000);
    // capacity below the count: each missing put evicts then inserts
    add_cap_write(5'd2);
    add_access(CMD_PUT, 32'h0000_0005, 32'h0000_0050);
    add_access(CMD_PUT, 32'h0000_0006, 32'h0000_0060);
    add_access(CMD_GET, 32'h8000_0000, 32'h0000_0000);
    // capacity zero: evicts but stores nothing; hits still update
    add_cap_write(5'd0);
    add_access(CMD_PUT, 32'h0000_0007, 32'h0000_0070);
    add_access(CMD_PUT, 32'h0000_0006, 32'hDEAD_BEEF);
    add_access(CMD_GET, 32'h0000_0007, 32'h0000_0000);
    add_access(CMD_GET, 32'h0000_0006, 32'h0000_0000);
    // capacity above the array size saturates
    add_cap_write(5'd31);
    add_access(CMD_PUT, 32'h0000_0008, 32'h0000_0080);
    add_access(CMD_PUT, 32'h0000_0009, 32'h0000_0090);
    add_access(CMD_GET, 32'h0000_0008, 32'h0000_0000);

    // Random phases: keys mostly from a pool a little larger than the capacity
    foreach (phase_caps[p]) begin
      add_cap_write(phase_caps[p]);
      eff_cap = (32'(phase_caps[p]) > CAPACITY) ? CAPACITY : 32'(phase_caps[p]);
      key_pool.delete();
      repeat (eff_cap + $urandom_range(1, 6)) key_pool.push_back($urandom);
      repeat (152) begin
        if ($urandom_range(0, 9) == 0) key = $urandom;
        else key = key_pool[$urandom_range(0, key_pool.size() - 1)];
        add_access(($urandom_range(0, 9) < 5) ? CMD_PUT : CMD_GET, key, $urandom);
      end
    end

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (!(pending_ops.size() == 0 && !in_valid_i && !cfg_valid_i && n_sent == n_seen))
      @(negedge clk_i);
    repeat (8) @(negedge clk_i);
    if (errors == 0 && expected_results.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin : watchdog
    #3_600_000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
